[rtl/core/imu_binary_frame_deframer_unit_assert.svh]
// Assertion macros shared by the deframer checker.
// No dependencies; include by bare file name.
`ifndef IMU_BINARY_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define IMU_BINARY_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define IMUBFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("imubfd: implication check failed");

// next-cycle implication
`define IMUBFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("imubfd: next-cycle check failed");

`endif

[rtl/core/imubfd_pkg.sv]
// Shared types and constants of the IMU binary frame deframer.
// No dependencies.
`default_nettype none

package imubfd_pkg;

  localparam logic [7:0] SYNC_LEAD   = 8'hAA;
  localparam logic [7:0] SYNC_DBL    = 8'h55;
  localparam logic [7:0] SYNC_DBL_ID = 8'h05;
  localparam logic [7:0] SYNC_INT    = 8'h44;
  localparam logic [7:0] SYNC_INT_ID = 8'h13;

  localparam int unsigned BODY_DBL_LEN = 54;
  localparam int unsigned BODY_INT_LEN = 46;
  localparam int unsigned HDR_INT_SKIP = 3;

  // the final body byte is taken straight from the input, the rest from the tap line
  localparam int unsigned TAP_CNT = BODY_DBL_LEN - 1;
  localparam int unsigned TAP_W   = TAP_CNT * 8;
  localparam int unsigned BODY_W  = BODY_DBL_LEN * 8;

  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] LAST_DBL = CNT_W'(BODY_DBL_LEN - 1);
  localparam logic [CNT_W-1:0] LAST_INT = CNT_W'(HDR_INT_SKIP + BODY_INT_LEN - 1);

  localparam int unsigned DATA_W = 32 + 6 * 64;

  typedef enum logic {
    KIND_DBL = 1'b0,
    KIND_INT = 1'b1
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e kind;
    logic [31:0] time_ms;
    logic [63:0] gyro_x;
    logic [63:0] gyro_y;
    logic [63:0] gyro_z;
    logic [63:0] accel_x;
    logic [63:0] accel_y;
    logic [63:0] accel_z;
  } imubfd_result_t;

endpackage

`default_nettype wire

[rtl/core/imubfd_extract.sv]
// Field extraction: maps the tap line onto the frame body and decodes
// the time and axis words. Depends on imubfd_pkg.
`default_nettype none

module imubfd_extract
  import imubfd_pkg::*;
(
  input  frame_kind_e    kind_i,
  input  logic [TAP_W-1:0] taps_i,     // tap 0 (bits 7:0) is the newest byte
  input  logic [7:0]     last_byte_i,
  output imubfd_result_t result_o
);

  logic [BODY_W-1:0] body_dbl;
  logic [BODY_W-1:0] body_int;
  logic [BODY_W-1:0] body;

  function automatic logic [63:0] sext32(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  always_comb begin
    body_dbl = '0;
    body_int = '0;
    for (int i = 0; i < BODY_DBL_LEN - 1; i++) begin
      body_dbl[i*8 +: 8] = taps_i[(BODY_DBL_LEN - 2 - i)*8 +: 8];
    end
    body_dbl[(BODY_DBL_LEN - 1)*8 +: 8] = last_byte_i;
    for (int i = 0; i < BODY_INT_LEN - 1; i++) begin
      body_int[i*8 +: 8] = taps_i[(BODY_INT_LEN - 2 - i)*8 +: 8];
    end
    body_int[(BODY_INT_LEN - 1)*8 +: 8] = last_byte_i;
    body = (kind_i == KIND_DBL) ? body_dbl : body_int;
  end

  always_comb begin
    result_o.kind    = kind_i;
    result_o.time_ms = body[2*8 +: 32];
    if (kind_i == KIND_DBL) begin
      result_o.gyro_x  = body[6*8  +: 64];
      result_o.gyro_y  = body[14*8 +: 64];
      result_o.gyro_z  = body[22*8 +: 64];
      result_o.accel_x = body[30*8 +: 64];
      result_o.accel_y = body[38*8 +: 64];
      result_o.accel_z = body[46*8 +: 64];
    end else begin
      // integer frame: axes stored in reverse order, y axes flipped
      result_o.gyro_x  = sext32(body[42*8 +: 32]);
      result_o.gyro_y  = 64'd0 - sext32(body[38*8 +: 32]);
      result_o.gyro_z  = sext32(body[34*8 +: 32]);
      result_o.accel_x = sext32(body[30*8 +: 32]);
      result_o.accel_y = 64'd0 - sext32(body[26*8 +: 32]);
      result_o.accel_z = sext32(body[22*8 +: 32]);
    end
  end

endmodule

`default_nettype wire

[rtl/core/imu_binary_frame_deframer_unit.sv]
// IMU binary frame deframer, top level.
// Hunts sync headers, collects frame bodies in a byte tap line and emits one
// result per frame. Depends on imubfd_pkg and imubfd_extract.
//
// Usage:
//   Slave stream takes one raw byte per transaction (tdata[7:0]); one byte can
//   be taken every cycle. Master stream gives one transaction per whole frame:
//   tuser = frame kind (0 double, 1 integer), tdata = time_ms, gyro_x/y/z,
//   accel_x/y/z from the lowest bit up.
//   Latency: the result is valid the cycle after the final body byte is taken.
//   Throughput: 1 byte per cycle outside a receiver stall; the decode is a single
//   pass from the state and tap registers into the output register.
//   Reset clears the hunt state and drops any result not yet taken.
//   Receiver stall: bytes keep flowing while a result waits; only the final
//   byte of the next frame is held off (tready low) until the waiting result
//   is taken.
`default_nettype none

module imu_binary_frame_deframer_unit
  import imubfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] data_byte
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [31:0] time_ms, [95:32] gyro_x, [159:96] gyro_y, [223:160] gyro_z,
  // [287:224] accel_x, [351:288] accel_y, [415:352] accel_z
  output logic [DATA_W-1:0] m_axis_tdata_o,
  output logic              m_axis_tuser_o    // [0] frame_kind
);

  logic [15:0]      sync_q, sync_d;
  logic             in_frame_q, in_frame_d;
  frame_kind_e      kind_q, kind_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [TAP_W-1:0] taps_q;
  logic             out_valid_q, out_valid_d;
  imubfd_result_t   result_q;
  imubfd_result_t   result;

  logic             in_acc;
  logic             frame_end;
  logic [CNT_W-1:0] last_cnt;

  assign last_cnt  = (kind_q == KIND_DBL) ? LAST_DBL : LAST_INT;
  assign frame_end = in_frame_q && (cnt_q == last_cnt);

  assign s_axis_tready_o = !(frame_end && out_valid_q && !m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  imubfd_extract u_extract (
    .kind_i      (kind_q),
    .taps_i      (taps_q),
    .last_byte_i (s_axis_tdata_i),
    .result_o    (result)
  );

  always_comb begin
    sync_d      = sync_q;
    in_frame_d  = in_frame_q;
    kind_d      = kind_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (in_acc) begin
      if (!in_frame_q) begin
        if (sync_q == {SYNC_LEAD, SYNC_DBL} && s_axis_tdata_i == SYNC_DBL_ID) begin
          in_frame_d = 1'b1;
          kind_d     = KIND_DBL;
          cnt_d      = '0;
          sync_d     = '0;
        end else if (sync_q == {SYNC_LEAD, SYNC_INT} && s_axis_tdata_i == SYNC_INT_ID) begin
          in_frame_d = 1'b1;
          kind_d     = KIND_INT;
          cnt_d      = '0;
          sync_d     = '0;
        end else begin
          sync_d = {sync_q[7:0], s_axis_tdata_i};
        end
      end else if (frame_end) begin
        in_frame_d  = 1'b0;
        cnt_d       = '0;
        sync_d      = '0;
        out_valid_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= '0;
      in_frame_q  <= 1'b0;
      kind_q      <= KIND_DBL;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sync_q      <= sync_d;
      in_frame_q  <= in_frame_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // byte tap line, shifted only by frame bytes
  always_ff @(posedge clk_i) begin
    if (in_acc && in_frame_q) begin
      taps_q <= {taps_q[TAP_W-9:0], s_axis_tdata_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && frame_end) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = result_q.kind;
  assign m_axis_tdata_o  = {result_q.accel_z, result_q.accel_y, result_q.accel_x,
                            result_q.gyro_z, result_q.gyro_y, result_q.gyro_x,
                            result_q.time_ms};

endmodule

`default_nettype wire

[rtl/core/imubfd_checker.sv]
// Port-level checker for the deframer top level, bound in below.
// Depends on imubfd_pkg and imu_binary_frame_deframer_unit_assert.svh.
`default_nettype none

`include "imu_binary_frame_deframer_unit_assert.svh"

module imubfd_checker
  import imubfd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_tready_i,
  input logic              m_tvalid_i,
  input logic              m_tready_i,
  input logic [DATA_W-1:0] m_tdata_i,
  input logic              m_tuser_i
);

  // input is only held off by a waiting result
  `IMUBFD_ASSERT_IMP(a_ready_only_on_stall, clk_i, rst_ni, !s_tready_i,
                     m_tvalid_i && !m_tready_i)

  // stalled result transaction stays put
  `IMUBFD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i,
                     m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))

  // integer frames: x rate and z rate are sign-extended words
  `IMUBFD_ASSERT_IMP(a_gx_sext, clk_i, rst_ni, m_tvalid_i && m_tuser_i,
                     m_tdata_i[95:64] == {32{m_tdata_i[63]}})
  `IMUBFD_ASSERT_IMP(a_gz_sext, clk_i, rst_ni, m_tvalid_i && m_tuser_i,
                     m_tdata_i[223:192] == {32{m_tdata_i[191]}})

endmodule

bind imu_binary_frame_deframer_unit imubfd_checker u_imubfd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire

[tb/sv/imu_binary_frame_deframer_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for imu_binary_frame_deframer_unit: streams directed and
// random IMU byte frames, predicts every decoded frame and checks each transaction.
// Depends on imubfd_pkg and the deframer RTL.
module imu_binary_frame_deframer_unit_test;
  import imubfd_pkg::*;

  localparam int unsigned RESET_CYCLES    = 8;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned PHASE_BYTES     = 200;
  localparam int unsigned PHASE_FRAMES    = 4;
  localparam int unsigned MAX_REPORTS     = 200;
  localparam int unsigned DBL_FRAME_BYTES = 3 + BODY_DBL_LEN;
  localparam int unsigned INT_FRAME_BYTES = 3 + HDR_INT_SKIP + BODY_INT_LEN;

  typedef enum logic [2:0] {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_HOLD
  } flow_phase_e;

  typedef enum logic [2:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_INT_MIN,
    FILL_INT_MAX,
    FILL_SYNC
  } body_fill_e;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              drv_valid = 1'b0;
  logic [7:0]        drv_byte  = '0;
  logic              rcv_ready = 1'b0;
  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  flow_phase_e phase       = PH_FREE;
  int unsigned hold_cnt    = 0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned dbl_frames  = 0;
  int unsigned int_frames  = 0;

  logic [7:0]     stream_bytes [$];
  imubfd_result_t pending_frames [$];

  // deframer state as the predictor sees it
  logic [15:0]      sync_win = '0;
  logic             in_frame = 1'b0;
  frame_kind_e      cur_kind = KIND_DBL;
  logic [CNT_W-1:0] body_cnt = '0;
  logic [7:0]       body [BODY_DBL_LEN];

  imu_binary_frame_deframer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (drv_valid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (drv_byte),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (rcv_ready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void append_byte(logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endfunction

  function automatic logic [63:0] body_le(int unsigned off, int unsigned n);
    logic [63:0] v;
    v = '0;
    for (int unsigned k = 0; k < n; k++) v |= 64'(body[off + k]) << (8 * k);
    return v;
  endfunction

  function automatic logic [63:0] body_int(int unsigned off, bit negate);
    logic [31:0] w;
    logic [63:0] sx;
    w  = 32'(body_le(off, 4));
    sx = {{32{w[31]}}, w};
    return negate ? -sx : sx;
  endfunction

  // Advance the deframer by one accepted byte; queue the decoded frame on its last byte.
  function automatic void deframe_byte(logic [7:0] b);
    imubfd_result_t r;
    if (!in_frame) begin
      if (sync_win == {SYNC_LEAD, SYNC_DBL} && b == SYNC_DBL_ID) begin
        in_frame = 1'b1;
        cur_kind = KIND_DBL;
        body_cnt = '0;
        sync_win = '0;
      end else if (sync_win == {SYNC_LEAD, SYNC_INT} && b == SYNC_INT_ID) begin
        in_frame = 1'b1;
        cur_kind = KIND_INT;
        body_cnt = '0;
        sync_win = '0;
      end else begin
        sync_win = {sync_win[7:0], b};
      end
      return;
    end
    if (cur_kind == KIND_DBL) begin
      body[body_cnt] = b;
      if (body_cnt != LAST_DBL) begin
        body_cnt++;
        return;
      end
      r.kind    = KIND_DBL;
      r.time_ms = 32'(body_le(2, 4));
      r.gyro_x  = body_le(6, 8);
      r.gyro_y  = body_le(14, 8);
      r.gyro_z  = body_le(22, 8);
      r.accel_x = body_le(30, 8);
      r.accel_y = body_le(38, 8);
      r.accel_z = body_le(46, 8);
    end else begin
      // the first bytes after the id are extra header, not body
      if (body_cnt >= HDR_INT_SKIP) body[body_cnt - HDR_INT_SKIP] = b;
      if (body_cnt != LAST_INT) begin
        body_cnt++;
        return;
      end
      r.kind    = KIND_INT;
      r.time_ms = 32'(body_le(2, 4));
      r.gyro_x  = body_int(42, 1'b0);
      r.gyro_y  = body_int(38, 1'b1);
      r.gyro_z  = body_int(34, 1'b0);
      r.accel_x = body_int(30, 1'b0);
      r.accel_y = body_int(26, 1'b1);
      r.accel_z = body_int(22, 1'b0);
    end
    pending_frames.insert(pending_frames.size(), r);
    in_frame = 1'b0;
    body_cnt = '0;
    sync_win = '0;
  endfunction

  function automatic bit sender_idle();
    case (phase)
      PH_SEND_IDLE: return $urandom_range(99) < 69;
      PH_BOTH:      return $urandom_range(99) < 10;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (phase)
      PH_RECV_STALL: return $urandom_range(99) < 69;
      PH_BOTH:       return $urandom_range(99) < 10;
      PH_HOLD:       return hold_cnt < HOLD_CYCLES;
      default:       return 1'b0;
    endcase
  endfunction

  // byte source biased toward the sync bytes
  function automatic logic [7:0] stream_noise();
    case ($urandom_range(7))
      0:       return SYNC_LEAD;
      1:       return SYNC_DBL;
      2:       return SYNC_INT;
      3:       return SYNC_DBL_ID;
      4:       return SYNC_INT_ID;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic check_frame();
    imubfd_result_t want;
    logic [63:0]    want_w [7];
    logic [63:0]    got_w [7];
    string          tag [7];
    if (pending_frames.size() == 0) begin
      if (error_count < MAX_REPORTS)
        $display("%0t: unexpected frame transaction, tuser %0b tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
      error_count++;
      return;
    end
    want   = pending_frames.pop_front();
    tag    = '{"time_ms", "gyro_x", "gyro_y", "gyro_z", "accel_x", "accel_y", "accel_z"};
    want_w = '{64'(want.time_ms), want.gyro_x, want.gyro_y, want.gyro_z,
               want.accel_x, want.accel_y, want.accel_z};
    got_w  = '{64'(m_axis_tdata[31:0]), m_axis_tdata[95:32], m_axis_tdata[159:96],
               m_axis_tdata[223:160], m_axis_tdata[287:224], m_axis_tdata[351:288],
               m_axis_tdata[415:352]};
    if (m_axis_tuser !== want.kind) begin
      if (error_count < MAX_REPORTS)
        $display("%0t: frame_kind expected %0b got %0b", $time, want.kind, m_axis_tuser);
      error_count++;
    end
    for (int i = 0; i < 7; i++) begin
      if (got_w[i] !== want_w[i]) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: %s expected %h got %h", $time, tag[i], want_w[i], got_w[i]);
        error_count++;
      end
    end
    if (want.kind == KIND_DBL) dbl_frames++;
    else int_frames++;
  endtask

  // driver: one byte per transaction from the stream queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_byte  <= '0;
    end else begin
      if (drv_valid && s_axis_tready) begin
        deframe_byte(drv_byte);
        bytes_sent++;
      end
      if (!drv_valid || s_axis_tready) begin
        if (stream_bytes.size() != 0 && !sender_idle()) begin
          drv_valid <= 1'b1;
          drv_byte  <= stream_bytes.pop_front();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each frame transaction, owns the long hold-off count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
      hold_cnt  <= 0;
    end else begin
      if (m_axis_tvalid && rcv_ready) check_frame();
      if (phase != PH_HOLD) hold_cnt <= 0;
      else if (hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
      rcv_ready <= !receiver_stall();
    end
  end

  always @(posedge clk_i) begin
    if ((drv_valid && s_axis_tready) || (m_axis_tvalid && rcv_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d frames outstanding",
               $time, WATCHDOG_LIMIT, pending_frames.size());
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_frame(frame_kind_e kind, body_fill_e fill);
    int unsigned len;
    logic [7:0]  b;
    append_byte(SYNC_LEAD);
    if (kind == KIND_DBL) begin
      append_byte(SYNC_DBL);
      append_byte(SYNC_DBL_ID);
      len = BODY_DBL_LEN;
    end else begin
      append_byte(SYNC_INT);
      append_byte(SYNC_INT_ID);
      repeat (HDR_INT_SKIP) append_byte(stream_noise());
      len = BODY_INT_LEN;
    end
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        // int words start at offset 22, so each top byte lands on i % 4 == 1
        FILL_INT_MIN: b = (i % 4 == 1) ? 8'h80 : 8'h00;
        FILL_INT_MAX: b = (i % 4 == 1) ? 8'h7F : 8'hFF;
        FILL_SYNC: begin
          // complete headers of both kinds inside the body, ending in a half header
          case (i % 3)
            0:       b = SYNC_LEAD;
            1:       b = (i % 6 == 1) ? SYNC_DBL : SYNC_INT;
            default: b = (i % 6 == 2) ? SYNC_DBL_ID : SYNC_INT_ID;
          endcase
          if (i == len - 2) b = SYNC_LEAD;
          if (i == len - 1) b = SYNC_DBL;
        end
        default: b = stream_noise();
      endcase
      append_byte(b);
    end
  endtask

  task automatic random_traffic();
    int unsigned n_bytes;
    int unsigned n_frames;
    frame_kind_e kind;
    body_fill_e  fill;
    logic [7:0]  id;
    n_bytes  = 0;
    n_frames = 0;
    while (n_bytes < PHASE_BYTES || n_frames < PHASE_FRAMES) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(8, 1)) append_byte(stream_noise());
        1: begin
          // header with a wrong id byte
          append_byte(SYNC_LEAD);
          append_byte($urandom_range(1) ? SYNC_DBL : SYNC_INT);
          id = stream_noise();
          if (id == SYNC_DBL_ID || id == SYNC_INT_ID) id = ~id;
          append_byte(id);
        end
        default: begin
          kind = frame_kind_e'($urandom_range(1));
          fill = ($urandom_range(9) < 8) ? FILL_RANDOM
                                         : body_fill_e'($urandom_range(FILL_SYNC));
          queue_frame(kind, fill);
          n_frames++;
          n_bytes += (kind == KIND_DBL) ? DBL_FRAME_BYTES : INT_FRAME_BYTES;
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (stream_bytes.size() != 0 || drv_valid || pending_frames.size() != 0);
  endtask

  task automatic set_phase(flow_phase_e p);
    @(posedge clk_i);
    phase <= p;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: overlapping lead byte, field extremes, int min and max
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(SYNC_LEAD);
    queue_frame(KIND_DBL, FILL_ZERO);
    queue_frame(KIND_DBL, FILL_ONES);
    queue_frame(KIND_INT, FILL_INT_MIN);
    queue_frame(KIND_INT, FILL_INT_MAX);
    // bodies full of headers; a trailing id byte must not complete the body's last half header
    queue_frame(KIND_DBL, FILL_SYNC);
    append_byte(SYNC_DBL_ID);
    queue_frame(KIND_INT, FILL_SYNC);
    append_byte(SYNC_DBL_ID);
    // near misses, then a kind-1 header overlapping an earlier partial one
    append_byte(SYNC_LEAD);
    append_byte(SYNC_DBL);
    append_byte(8'h06);
    append_byte(SYNC_LEAD);
    append_byte(SYNC_INT);
    append_byte(SYNC_DBL_ID);
    append_byte(SYNC_LEAD);
    append_byte(SYNC_DBL);
    append_byte(SYNC_INT_ID);
    append_byte(SYNC_INT);
    append_byte(SYNC_INT_ID);
    append_byte(SYNC_LEAD);
    append_byte(SYNC_INT);
    queue_frame(KIND_INT, FILL_RANDOM);
    queue_frame(KIND_DBL, FILL_RANDOM);
    wait_drained();

    // receiver holds off while frames keep coming, so the input backs up
    set_phase(PH_HOLD);
    repeat (3) queue_frame(frame_kind_e'($urandom_range(1)), FILL_RANDOM);
    wait_drained();

    set_phase(PH_FREE);
    random_traffic();
    wait_drained();
    set_phase(PH_SEND_IDLE);
    random_traffic();
    wait_drained();
    set_phase(PH_RECV_STALL);
    random_traffic();
    wait_drained();
    set_phase(PH_BOTH);
    random_traffic();
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("summary: %0d bytes streamed, %0d double and %0d integer frames decoded,",
             bytes_sent, dbl_frames, int_frames);
    $display("summary: under free flow, sender gaps, receiver stalls and a long hold-off");
    if (error_count == 0 && pending_frames.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/imubfd_pkg.sv
rtl/core/imubfd_extract.sv
rtl/core/imu_binary_frame_deframer_unit.sv
rtl/core/imubfd_checker.sv
tb/sv/imu_binary_frame_deframer_unit_test.sv
